// File: rtl/fptm_pkg.sv
`timescale 1ns / 1ps
// Shared widths, codes and state encoding for the page table mapper.
// No dependencies; every other file imports this package.
package fptm_pkg;

   localparam int VA_W              = 48;
   localparam int PA_W              = 52;
   localparam int FLAG_W            = 12;
   localparam int PAGE_SHIFT        = 12;
   localparam int IDX_W             = 9;
   localparam int FIELD_W           = PA_W - PAGE_SHIFT;   // address bits 51..12
   localparam int VPN_W             = VA_W - PAGE_SHIFT;   // address bits 47..12
   localparam int ENTRY_W           = FIELD_W + FLAG_W;    // address field above the flag bits
   localparam int ENTRIES_PER_TABLE = 512;
   localparam int LEVELS            = 4;
   localparam int LVL_W             = 2;
   localparam int LEVEL_OUT_W       = 3;
   localparam int STATUS_W          = 2;
   localparam int CSR_IDX_W         = 1;

   localparam logic [CSR_IDX_W-1:0] CSR_ROOT_BASE = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_POOL_BASE = 1'b1;

   localparam logic [PA_W-1:0] ROOT_BASE_RESET = 52'd4096;
   localparam logic [PA_W-1:0] POOL_BASE_RESET = 52'd2097152;

   typedef enum logic {
      ACT_MAP    = 1'b0,
      ACT_LOOKUP = 1'b1
   } action_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK       = 2'd0,
      STATUS_NO_TABLE = 2'd1,
      STATUS_OUTSIDE  = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_EVAL,
      ST_LEAF
   } walk_state_type;

endpackage

// File: rtl/fptm_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for request, response and register writes.
// Depends on fptm_pkg for field widths.
interface fptm_req_if import fptm_pkg::*; ();
   logic                valid;
   logic                ready;
   logic                action;
   logic [VA_W-1:0]     virt_address;
   logic [FLAG_W-1:0]   entry_flags_in;

   modport source(output valid, action, virt_address, entry_flags_in, input ready);
   modport sink(input valid, action, virt_address, entry_flags_in, output ready);
endinterface

interface fptm_rsp_if import fptm_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [LEVEL_OUT_W-1:0] level;
   logic [IDX_W-1:0]       table_index;
   logic                   entry_present;
   logic [PA_W-1:0]        entry_address;
   logic [FLAG_W-1:0]      entry_flags_out;
   logic [STATUS_W-1:0]    status;
   logic                   last;

   modport source(output valid, level, table_index, entry_present, entry_address,
                  entry_flags_out, status, last, input ready);
   modport sink(input valid, level, table_index, entry_present, entry_address,
                entry_flags_out, status, last, output ready);
endinterface

interface fptm_csr_if import fptm_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [PA_W-1:0]      data;

   modport source(output valid, index, data, input ready);
   modport sink(input valid, index, data, output ready);
endinterface

// File: rtl/fptm_store.sv
`timescale 1ns / 1ps
// Table store: one write port, one read port with registered read data.
// Depends on fptm_pkg.
module fptm_store import fptm_pkg::*; #(
   parameter int DEPTH = 8192,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic               clock,
   input  logic               wr_en,
   input  logic [AW-1:0]      wr_addr,
   input  logic [ENTRY_W-1:0] wr_data,
   input  logic [AW-1:0]      rd_addr,
   output logic [ENTRY_W-1:0] rd_data
);

   logic [ENTRY_W-1:0] mem_ff [DEPTH];
   logic [ENTRY_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/fptm_walk.sv
`timescale 1ns / 1ps
// Walk sequencer: store clear after reset, per-level read/evaluate, table
// allocation, leaf write and the response register. Depends on fptm_pkg, fptm_if.
module fptm_walk import fptm_pkg::*; #(
   parameter int POOL_TABLES = 15,
   localparam int TW = $clog2(POOL_TABLES + 1),
   localparam int AW = TW + IDX_W
) (
   input  logic               clock,
   input  logic               reset,
   input  logic [PA_W-1:0]    root_base,
   input  logic [PA_W-1:0]    pool_base,
   fptm_req_if.sink           req_chan,
   fptm_rsp_if.source         rsp_chan,
   output logic               mem_wr_en,
   output logic [AW-1:0]      mem_wr_addr,
   output logic [ENTRY_W-1:0] mem_wr_data,
   output logic [AW-1:0]      mem_rd_addr,
   input  logic [ENTRY_W-1:0] mem_rd_data
);

   localparam int DEPTH = (POOL_TABLES + 1) * ENTRIES_PER_TABLE;
   localparam logic [AW-1:0] CLR_LAST = AW'(DEPTH - 1);

   typedef struct packed {
      logic [LEVEL_OUT_W-1:0] level;
      logic [IDX_W-1:0]       table_index;
      logic                   entry_present;
      logic [PA_W-1:0]        entry_address;
      logic [FLAG_W-1:0]      entry_flags_out;
      status_type             status;
      logic                   last;
   } rsp_item_type;

   walk_state_type      state_ff, state_in;
   logic [AW-1:0]       clr_ff, clr_in;
   logic [TW-1:0]       nft_ff, nft_in;
   logic [FIELD_W-1:0]  alloc_ff, alloc_in;
   action_type          action_ff, action_in;
   logic [VPN_W-1:0]    va_ff, va_in;
   logic [FLAG_W-1:0]   flags_ff, flags_in;
   logic [TW-1:0]       table_ff, table_in;
   logic [LVL_W-1:0]    lvl_ff, lvl_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_item_type        rsp_item_ff, rsp_item_in;

   logic [FIELD_W-1:0]  root_field, pool_field, ent_field, diff, leaf_field;
   logic [FLAG_W-1:0]   ent_flags;
   logic [IDX_W-1:0]    cur_idx;
   logic [TW-1:0]       res_table, alloc_table;
   logic                present, eq_root, in_pool, hit, pool_empty, last_level;
   logic                out_free, need_out, finish, alloc_now, stall, emit;
   status_type          eval_status;
   rsp_item_type        item;

   assign root_field = root_base[PA_W-1:PAGE_SHIFT];
   assign pool_field = pool_base[PA_W-1:PAGE_SHIFT];
   assign ent_field  = mem_rd_data[ENTRY_W-1:FLAG_W];
   assign ent_flags  = mem_rd_data[FLAG_W-1:0];
   assign cur_idx    = va_ff[IDX_W*lvl_ff +: IDX_W];
   assign leaf_field = FIELD_W'(va_ff);

   // entry address -> table number: root first, then the pool window
   assign present     = |ent_field;
   assign eq_root     = ent_field == root_field;
   assign diff        = ent_field - pool_field;
   assign in_pool     = diff < FIELD_W'(POOL_TABLES);
   assign hit         = eq_root || in_pool;
   assign res_table   = eq_root ? '0 : diff[TW-1:0] + TW'(1);
   assign alloc_table = (alloc_ff == root_field) ? '0 : nft_ff + TW'(1);
   assign pool_empty  = nft_ff == TW'(POOL_TABLES);
   assign last_level  = lvl_ff == '0;
   assign out_free    = !rsp_valid_ff || rsp_chan.ready;

   assign mem_rd_addr = {table_ff, cur_idx};
   assign mem_wr_addr = (state_ff == ST_CLEAR) ? clr_ff : mem_rd_addr;

   // per-level decision on the entry just read
   always_comb begin
      need_out    = 1'b0;
      finish      = 1'b0;
      alloc_now   = 1'b0;
      eval_status = STATUS_OK;
      unique case (action_ff)
         ACT_LOOKUP: begin
            need_out = 1'b1;
            if (!present || last_level) begin
               finish = 1'b1;
            end else if (!hit) begin
               finish      = 1'b1;
               eval_status = STATUS_OUTSIDE;
            end
         end
         ACT_MAP: begin
            if (!present) begin
               if (pool_empty) begin
                  need_out    = 1'b1;
                  finish      = 1'b1;
                  eval_status = STATUS_NO_TABLE;
               end else begin
                  alloc_now = 1'b1;
               end
            end else if (!hit) begin
               need_out    = 1'b1;
               finish      = 1'b1;
               eval_status = STATUS_OUTSIDE;
            end
         end
         default: begin
            finish = 1'b1;
         end
      endcase
      stall = need_out && !out_free;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (clr_ff == CLR_LAST) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_chan.valid) state_in = ST_READ;
         end
         ST_READ: begin
            state_in = ST_EVAL;
         end
         ST_EVAL: begin
            if (!stall) begin
               if (finish) begin
                  state_in = ST_IDLE;
               end else if (action_ff == ACT_MAP && lvl_ff == LVL_W'(1)) begin
                  state_in = ST_LEAF;
               end else begin
                  state_in = ST_READ;
               end
            end
         end
         ST_LEAF: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // datapath and store writes
   always_comb begin
      clr_in      = clr_ff;
      nft_in      = nft_ff;
      alloc_in    = pool_field + FIELD_W'(nft_ff);
      action_in   = action_ff;
      va_in       = va_ff;
      flags_in    = flags_ff;
      table_in    = table_ff;
      lvl_in      = lvl_ff;
      mem_wr_en   = 1'b0;
      mem_wr_data = '0;
      emit        = 1'b0;

      item.level           = LEVEL_OUT_W'(lvl_ff) + LEVEL_OUT_W'(1);
      item.table_index     = cur_idx;
      item.entry_present   = present;
      item.entry_address   = {ent_field, {PAGE_SHIFT{1'b0}}};
      item.entry_flags_out = ent_flags;
      item.status          = eval_status;
      item.last            = finish;

      unique case (state_ff)
         ST_CLEAR: begin
            mem_wr_en = 1'b1;
            clr_in    = clr_ff + AW'(1);
         end
         ST_IDLE: begin
            if (req_chan.valid) begin
               action_in = action_type'(req_chan.action);
               va_in     = req_chan.virt_address[VA_W-1:PAGE_SHIFT];
               flags_in  = req_chan.entry_flags_in;
               table_in  = '0;
               lvl_in    = LVL_W'(LEVELS - 1);
            end
         end
         ST_READ: begin
         end
         ST_EVAL: begin
            if (!stall) begin
               emit = need_out;
               if (alloc_now) begin
                  mem_wr_en   = 1'b1;
                  mem_wr_data = {alloc_ff, flags_ff};
                  nft_in      = nft_ff + TW'(1);
               end
               if (!finish) begin
                  table_in = alloc_now ? alloc_table : res_table;
                  lvl_in   = lvl_ff - LVL_W'(1);
               end
            end
         end
         ST_LEAF: begin
            item.entry_present   = |va_ff;
            item.entry_address   = {leaf_field, {PAGE_SHIFT{1'b0}}};
            item.entry_flags_out = flags_ff;
            item.status          = STATUS_OK;
            item.last            = 1'b1;
            if (out_free) begin
               emit        = 1'b1;
               mem_wr_en   = 1'b1;
               mem_wr_data = {leaf_field, flags_ff};
            end
         end
         default: begin
         end
      endcase

      rsp_item_in  = emit ? item : rsp_item_ff;
      rsp_valid_in = emit || (rsp_valid_ff && !rsp_chan.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         nft_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         nft_ff       <= nft_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      alloc_ff    <= alloc_in;
      action_ff   <= action_in;
      va_ff       <= va_in;
      flags_ff    <= flags_in;
      table_ff    <= table_in;
      lvl_ff      <= lvl_in;
      rsp_item_ff <= rsp_item_in;
   end

   assign req_chan.ready           = state_ff == ST_IDLE;
   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.level           = rsp_item_ff.level;
   assign rsp_chan.table_index     = rsp_item_ff.table_index;
   assign rsp_chan.entry_present   = rsp_item_ff.entry_present;
   assign rsp_chan.entry_address   = rsp_item_ff.entry_address;
   assign rsp_chan.entry_flags_out = rsp_item_ff.entry_flags_out;
   assign rsp_chan.status          = rsp_item_ff.status;
   assign rsp_chan.last            = rsp_item_ff.last;

endmodule

// File: rtl/four_level_page_table_mapper_core.sv
`timescale 1ns / 1ps
// Four-level page table mapper. After reset the block zeroes its table store,
// holding req_chan.ready low while it does; register writes are taken
// throughout. Items are handled one at a time, each table level taking a store
// read state and an evaluate state: a map walks three levels and then writes the
// leaf before the next acceptance, a lookup walks up to four levels.
// A full response register sits on the output; a walk stalls only when a new
// response is due while the previous one has not been taken.
// Depends on fptm_pkg, fptm_if, fptm_store, fptm_walk.
module four_level_page_table_mapper_core import fptm_pkg::*; #(
   parameter int POOL_TABLES = 15
) (
   input  logic       clock,
   input  logic       reset,
   fptm_req_if.sink   req_chan,
   fptm_rsp_if.source rsp_chan,
   fptm_csr_if.sink   csr_chan
);

   localparam int TW    = $clog2(POOL_TABLES + 1);
   localparam int AW    = TW + IDX_W;
   localparam int DEPTH = (POOL_TABLES + 1) * ENTRIES_PER_TABLE;

   logic [PA_W-1:0]    root_base_ff, root_base_in;
   logic [PA_W-1:0]    pool_base_ff, pool_base_in;
   logic               mem_wr_en;
   logic [AW-1:0]      mem_wr_addr, mem_rd_addr;
   logic [ENTRY_W-1:0] mem_wr_data, mem_rd_data;

   assign csr_chan.ready = 1'b1;

   always_comb begin
      root_base_in = root_base_ff;
      pool_base_in = pool_base_ff;
      if (csr_chan.valid) begin
         unique case (csr_chan.index)
            CSR_ROOT_BASE: root_base_in = csr_chan.data;
            CSR_POOL_BASE: pool_base_in = csr_chan.data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         root_base_ff <= ROOT_BASE_RESET;
         pool_base_ff <= POOL_BASE_RESET;
      end else begin
         root_base_ff <= root_base_in;
         pool_base_ff <= pool_base_in;
      end
   end

   fptm_store #(
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   fptm_walk #(
      .POOL_TABLES (POOL_TABLES)
   ) u_walk (
      .clock       (clock),
      .reset       (reset),
      .root_base   (root_base_ff),
      .pool_base   (pool_base_ff),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data),
      .mem_rd_addr (mem_rd_addr),
      .mem_rd_data (mem_rd_data)
   );

endmodule

// File: bench/tb.sv
`timescale 1ns / 1ps
// Self-checking bench for four_level_page_table_mapper_core: map/lookup walks checked
// against an in-bench page table predictor. Depends on fptm_pkg, fptm_if and the core.
module tb;
   import fptm_pkg::*;

   localparam int POOL_TABLES   = 15;
   localparam int STORE_ENTRIES = (POOL_TABLES + 1) * ENTRIES_PER_TABLE;
   localparam int HOLD_CYCLES   = 250;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int HISTORY_DEPTH = 64;

   localparam logic [PA_W-1:0] PAGE_MASK = {{FIELD_W{1'b1}}, {PAGE_SHIFT{1'b0}}};
   // root off the pool's way; pool starts two tables below the top so it wraps to zero
   localparam logic [PA_W-1:0] ROOT_MID  = 52'h0_0000_8000_0123;
   localparam logic [PA_W-1:0] POOL_WRAP = 52'hF_FFFF_FFFF_E000;
   localparam logic [PA_W-1:0] PA_MAX    = 52'hF_FFFF_FFFF_FFFF;

   typedef struct packed {
      logic [LEVEL_OUT_W-1:0] level;
      logic [IDX_W-1:0]       table_index;
      logic                   present;
      logic [PA_W-1:0]        address;
      logic [FLAG_W-1:0]      flags;
      status_type             status;
      logic                   last;
   } walk_report_type;

   typedef struct packed {
      action_type         action;
      logic [VA_W-1:0]    va;
      logic [FLAG_W-1:0]  flags;
      logic               has_report;
      walk_report_type    report;
   } directed_row_type;

   localparam walk_report_type NO_REPORT = '0;

   logic clock = 1'b0;
   logic reset;

   fptm_req_if req_chan();
   fptm_rsp_if rsp_chan();
   fptm_csr_if csr_chan();

   four_level_page_table_mapper_core #(
      .POOL_TABLES(POOL_TABLES)
   ) u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // predictor state
   bit [PA_W-1:0]  page_store [STORE_ENTRIES];
   int             pool_used;
   bit [PA_W-1:0]  cfg_root;
   bit [PA_W-1:0]  cfg_pool;

   walk_report_type   predicted[$];
   walk_report_type   pending_reports[$];
   bit [VA_W-1:0]     mapped_va[$];
   directed_row_type  directed_rows[$];

   int             send_idle_pct;
   int             recv_idle_pct;
   int             error_count   = 0;
   int             hold_requests = 0;
   int             holds_served  = 0;
   int             hold_left     = 0;
   int unsigned    cycle_count   = 0;

   // table number behind an entry address, -1 when it lands outside the store
   function automatic int table_of(bit [PA_W-1:0] addr);
      bit [PA_W-1:0] a;
      bit [PA_W-1:0] k;
      a = addr & PAGE_MASK;
      if (a == (cfg_root & PAGE_MASK)) return 0;
      k = (a - (cfg_pool & PAGE_MASK)) >> PAGE_SHIFT;
      if (k < POOL_TABLES) return int'(k) + 1;
      return -1;
   endfunction

   function automatic walk_report_type make_report(int lvl, bit [IDX_W-1:0] idx,
                                                   bit [PA_W-1:0] ent, status_type st,
                                                   bit fin);
      walk_report_type r;
      r.level       = LEVEL_OUT_W'(lvl);
      r.table_index = idx;
      r.address     = ent & PAGE_MASK;
      r.present     = (r.address != '0);
      r.flags       = ent[FLAG_W-1:0];
      r.status      = st;
      r.last        = fin;
      return r;
   endfunction

   function automatic void predict_walk(action_type act, bit [VA_W-1:0] va,
                                        bit [FLAG_W-1:0] flags);
      int            tbl;
      int            pos;
      bit [IDX_W-1:0] idx;
      bit [PA_W-1:0] ent;
      bit [PA_W-1:0] nxt;
      tbl = table_of(cfg_root);
      if (act == ACT_MAP) begin
         for (int lvl = LEVELS; lvl > 1; lvl--) begin
            idx = va[PAGE_SHIFT + IDX_W*(lvl-1) +: IDX_W];
            pos = tbl * ENTRIES_PER_TABLE + int'(idx);
            ent = page_store[pos];
            nxt = ent & PAGE_MASK;
            if (nxt == '0) begin
               if (pool_used >= POOL_TABLES) begin
                  predicted.push_back(make_report(lvl, idx, ent, STATUS_NO_TABLE, 1'b1));
                  return;
               end
               nxt = ((cfg_pool & PAGE_MASK) + (PA_W'(pool_used) << PAGE_SHIFT)) & PAGE_MASK;
               pool_used++;
               ent = nxt | PA_W'(flags);
               page_store[pos] = ent;
            end
            tbl = table_of(nxt);
            if (tbl < 0) begin
               predicted.push_back(make_report(lvl, idx, ent, STATUS_OUTSIDE, 1'b1));
               return;
            end
         end
         idx = va[PAGE_SHIFT +: IDX_W];
         ent = (PA_W'(va) & PAGE_MASK) | PA_W'(flags);
         page_store[tbl * ENTRIES_PER_TABLE + int'(idx)] = ent;
         predicted.push_back(make_report(1, idx, ent, STATUS_OK, 1'b1));
         return;
      end
      for (int lvl = LEVELS; lvl >= 1; lvl--) begin
         idx = va[PAGE_SHIFT + IDX_W*(lvl-1) +: IDX_W];
         ent = page_store[tbl * ENTRIES_PER_TABLE + int'(idx)];
         nxt = ent & PAGE_MASK;
         if (nxt == '0 || lvl == 1) begin
            predicted.push_back(make_report(lvl, idx, ent, STATUS_OK, 1'b1));
            return;
         end
         tbl = table_of(nxt);
         if (tbl < 0) begin
            predicted.push_back(make_report(lvl, idx, ent, STATUS_OUTSIDE, 1'b1));
            return;
         end
         predicted.push_back(make_report(lvl, idx, ent, STATUS_OK, 1'b0));
      end
   endfunction

   function automatic void compare_field(string name, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         error_count++;
      end
   endfunction

   task automatic check_response();
      walk_report_type want;
      if (pending_reports.size() == 0) begin
         $error("response with no transaction outstanding: level %0d index %0d",
                rsp_chan.level, rsp_chan.table_index);
         error_count++;
         return;
      end
      want = pending_reports.pop_front();
      compare_field("level", 64'(want.level), 64'(rsp_chan.level));
      compare_field("table_index", 64'(want.table_index), 64'(rsp_chan.table_index));
      compare_field("entry_present", 64'(want.present), 64'(rsp_chan.entry_present));
      compare_field("entry_address", 64'(want.address), 64'(rsp_chan.entry_address));
      compare_field("entry_flags_out", 64'(want.flags), 64'(rsp_chan.entry_flags_out));
      compare_field("status", 64'(want.status), 64'(rsp_chan.status));
      compare_field("last", 64'(want.last), 64'(rsp_chan.last));
   endtask

   // response side: random stalls, plus a long hold-off when one is requested
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) check_response();
         if (hold_requests != holds_served) begin
            holds_served = hold_requests;
            hold_left = HOLD_CYCLES;
            rsp_chan.ready <= 1'b0;
         end else if (hold_left > 0) begin
            hold_left--;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   // both registers back to back; valid stays high across the pair
   task automatic write_config(bit [PA_W-1:0] root, bit [PA_W-1:0] pool);
      csr_chan.valid <= 1'b1;
      csr_chan.index <= CSR_ROOT_BASE;
      csr_chan.data  <= root;
      do @(posedge clock); while (!csr_chan.ready);
      cfg_root = root;
      csr_chan.index <= CSR_POOL_BASE;
      csr_chan.data  <= pool;
      do @(posedge clock); while (!csr_chan.ready);
      cfg_pool = pool;
      csr_chan.valid <= 1'b0;
   endtask

   // valid is left high after acceptance; the next idle cycle or drain lowers it
   task automatic offer_request(action_type act, bit [VA_W-1:0] va, bit [FLAG_W-1:0] flags,
                                bit has_report, walk_report_type want);
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid          <= 1'b1;
      req_chan.action         <= act;
      req_chan.virt_address   <= va;
      req_chan.entry_flags_in <= flags;
      do @(posedge clock); while (!req_chan.ready);
      predicted.delete();
      predict_walk(act, va, flags);
      if (has_report) pending_reports.push_back(want);
      else foreach (predicted[i]) pending_reports.push_back(predicted[i]);
      if (act == ACT_MAP) begin
         mapped_va.push_back(va);
         if (mapped_va.size() > HISTORY_DEPTH) void'(mapped_va.pop_front());
      end
   endtask

   task automatic drain_responses();
      req_chan.valid <= 1'b0;
      while (pending_reports.size() != 0) @(posedge clock);
   endtask

   // mostly revisits of mapped paths so walks get past the top levels
   task automatic run_random(int count);
      bit [VA_W-1:0] va;
      bit [VA_W-1:0] base;
      action_type    act;
      int            pick;
      repeat (count) begin
         pick = $urandom_range(99);
         va   = VA_W'({$urandom(), $urandom()});
         if (mapped_va.size() > 0 && pick < 85) begin
            base = mapped_va[$urandom_range(mapped_va.size() - 1)];
            if (pick < 20) va = base;
            else if (pick < 65) va = {base[VA_W-1:21], va[20:0]};
            else va = {base[VA_W-1:30], va[29:0]};
         end
         act = ($urandom_range(99) < 45) ? ACT_MAP : ACT_LOOKUP;
         offer_request(act, va, FLAG_W'($urandom_range(4095)), 1'b0, NO_REPORT);
      end
   endtask

   initial begin
      reset                   <= 1'b1;
      req_chan.valid          <= 1'b0;
      req_chan.action         <= ACT_MAP;
      req_chan.virt_address   <= '0;
      req_chan.entry_flags_in <= '0;
      csr_chan.valid          <= 1'b0;
      csr_chan.index          <= CSR_ROOT_BASE;
      csr_chan.data           <= '0;
      cfg_root      = ROOT_BASE_RESET;
      cfg_pool      = POOL_BASE_RESET;
      pool_used     = 0;
      send_idle_pct = 38;
      recv_idle_pct = 52;

      // typed reports: empty store, identity leaves, pool exhaustion
      directed_rows.push_back('{ACT_LOOKUP, 48'h0, 12'h000, 1'b1,
         '{3'd4, 9'd0, 1'b0, 52'h0, 12'h000, STATUS_OK, 1'b1}});
      directed_rows.push_back('{ACT_LOOKUP, 48'hFFFF_FFFF_FFFF, 12'hFFF, 1'b1,
         '{3'd4, 9'd511, 1'b0, 52'h0, 12'h000, STATUS_OK, 1'b1}});
      // third pool table lands on address zero, so the level 2 entry reads absent
      directed_rows.push_back('{ACT_MAP, 48'h0, 12'h000, 1'b1,
         '{3'd1, 9'd0, 1'b0, 52'h0, 12'h000, STATUS_OK, 1'b1}});
      directed_rows.push_back('{ACT_LOOKUP, 48'h0, 12'h000, 1'b0, NO_REPORT});
      directed_rows.push_back('{ACT_MAP, 48'h0, 12'h800, 1'b0, NO_REPORT});
      directed_rows.push_back('{ACT_LOOKUP, 48'h0, 12'h000, 1'b0, NO_REPORT});
      directed_rows.push_back('{ACT_MAP, 48'hFFFF_FFFF_FFFF, 12'hFFF, 1'b1,
         '{3'd1, 9'd511, 1'b1, 52'h0_FFFF_FFFF_F000, 12'hFFF, STATUS_OK, 1'b1}});
      directed_rows.push_back('{ACT_LOOKUP, 48'hFFFF_FFFF_FFFF, 12'h000, 1'b0, NO_REPORT});
      directed_rows.push_back('{ACT_MAP, 48'h0000_0000_1000, 12'h5A5, 1'b0, NO_REPORT});
      directed_rows.push_back('{ACT_LOOKUP, 48'h0000_0000_1000, 12'h000, 1'b0, NO_REPORT});
      directed_rows.push_back('{ACT_MAP, 48'h0080_0000_0000, 12'h001, 1'b0, NO_REPORT});
      directed_rows.push_back('{ACT_MAP, 48'h0100_0000_0000, 12'h002, 1'b0, NO_REPORT});
      directed_rows.push_back('{ACT_MAP, 48'h0180_0000_0000, 12'h7FF, 1'b0, NO_REPORT});
      directed_rows.push_back('{ACT_MAP, 48'h0200_0000_0000, 12'h3C3, 1'b1,
         '{3'd4, 9'd4, 1'b0, 52'h0, 12'h000, STATUS_NO_TABLE, 1'b1}});
      directed_rows.push_back('{ACT_MAP, 48'h0000_4000_0000, 12'hABC, 1'b1,
         '{3'd3, 9'd1, 1'b0, 52'h0, 12'h000, STATUS_NO_TABLE, 1'b1}});
      directed_rows.push_back('{ACT_LOOKUP, 48'h0180_0000_0000, 12'h000, 1'b0, NO_REPORT});
      directed_rows.push_back('{ACT_LOOKUP, 48'h0000_4000_0000, 12'h000, 1'b0, NO_REPORT});
      directed_rows.push_back('{ACT_MAP, 48'h0000_001F_F000, 12'hFFF, 1'b0, NO_REPORT});
      directed_rows.push_back('{ACT_LOOKUP, 48'h8000_0000_0000, 12'h000, 1'b1,
         '{3'd4, 9'd256, 1'b0, 52'h0, 12'h000, STATUS_OK, 1'b1}});
      directed_rows.push_back('{ACT_MAP, 48'hFFFF_FFE0_0ABC, 12'h000, 1'b0, NO_REPORT});

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      write_config(ROOT_MID, POOL_WRAP);
      foreach (directed_rows[i])
         offer_request(directed_rows[i].action, directed_rows[i].va, directed_rows[i].flags,
                       directed_rows[i].has_report, directed_rows[i].report);
      run_random(140);
      drain_responses();

      // old pool pointers now resolve to different tables of the store
      send_idle_pct = 52;
      recv_idle_pct = 38;
      write_config(PA_MAX, '0);
      run_random(100);
      drain_responses();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      write_config('0, PA_MAX);
      run_random(80);
      drain_responses();

      write_config(ROOT_MID, POOL_WRAP);
      run_random(40);
      // long response stall while requests keep coming
      hold_requests++;
      run_random(40);
      drain_responses();
      run_random(60);
      drain_responses();

      repeat (40) @(posedge clock);
      if (pending_reports.size() != 0) begin
         $error("%0d responses never arrived", pending_reports.size());
         error_count++;
      end
      if (error_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

// File: sim.f
rtl/fptm_pkg.sv
rtl/fptm_if.sv
rtl/fptm_store.sv
rtl/fptm_walk.sv
rtl/four_level_page_table_mapper_core.sv
bench/tb.sv
